// File: rtl/core/htclip_pkg.sv
package htclip_pkg;

    localparam int COORD_W     = 32;
    localparam int MAX_VERTS   = 10;
    localparam int NUM_PLANES  = 7;
    localparam int IDX_W       = 4;
    localparam int DIST_W      = 34;
    localparam int DEN_W       = 35;
    localparam int S_TDATA_W   = 384;
    localparam int M_TDATA_W   = 136;

    localparam logic [2:0] PL_W_POS  = 3'd0;
    localparam logic [2:0] PL_Z_NEAR = 3'd1;
    localparam logic [2:0] PL_Z_FAR  = 3'd2;
    localparam logic [2:0] PL_X_LEFT = 3'd3;
    localparam logic [2:0] PL_X_RGHT = 3'd4;
    localparam logic [2:0] PL_Y_TOP  = 3'd5;
    localparam logic [2:0] PL_Y_BOT  = 3'd6;

    // Coordinates x, y, z, w at index 0..3
    typedef logic [3:0][COORD_W-1:0] vtx_t;

    function automatic logic signed [DIST_W-1:0] htclip_dist(vtx_t v, logic [2:0] plane);
        logic signed [DIST_W-1:0] x;
        logic signed [DIST_W-1:0] y;
        logic signed [DIST_W-1:0] z;
        logic signed [DIST_W-1:0] w;
        logic signed [DIST_W-1:0] d;
        x = DIST_W'($signed(v[0]));
        y = DIST_W'($signed(v[1]));
        z = DIST_W'($signed(v[2]));
        w = DIST_W'($signed(v[3]));
        unique case (plane)
            PL_W_POS:  d = w;
            PL_Z_NEAR: d = z + w;
            PL_Z_FAR:  d = w - z;
            PL_X_LEFT: d = x + w;
            PL_X_RGHT: d = w - x;
            PL_Y_TOP:  d = w - y;
            PL_Y_BOT:  d = y + w;
            default:   d = w;
        endcase
        return d;
    endfunction

    function automatic logic [DEN_W-1:0] htclip_mag(logic signed [DEN_W-1:0] v);
        return v[DEN_W-1] ? DEN_W'(-v) : DEN_W'(v);
    endfunction

endpackage

// File: rtl/core/homogeneous_triangle_clipper_top.sv
// Clips one triangle in clip space against w>0, the near/far z planes and the x and y
// frustum planes, one plane at a time, and streams the surviving polygon (up to ten
// vertices, tlast on the final one; nothing at all when the triangle is fully culled).
// A single sequencer walks each polygon edge; every crossing runs one bit-per-cycle
// divider and one shared multiplier over the four coordinates.
// The input is not ready again until the last vertex is taken or the triangle is culled.
module homogeneous_triangle_clipper_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // v0_x, v0_y, v0_z, v0_w, v1_x .. v2_w, 32 bits each
    input  logic [htclip_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x, out_y, out_z, out_w (32 bits each), vertex_number (4 bits), 4 zero bits
    output logic [htclip_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import htclip_pkg::*;

    localparam int Q_W   = FRACTION_BITS + 1;
    localparam int PW    = FRACTION_BITS + 35;
    localparam int CNT_W = $clog2(FRACTION_BITS + 2);
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_VISIT = 4'd1;
    localparam logic [3:0] ST_KEEP  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_PUSHX = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]               state_reg;
    logic                     bank_reg;
    logic [IDX_W-1:0]         n_reg;
    logic [IDX_W-1:0]         m_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [2:0]               plane_reg;
    logic                     closing_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               k_reg;

    vtx_t                     vmem_reg [2][MAX_VERTS];
    vtx_t                     prev_reg;
    vtx_t                     cur_reg;
    vtx_t                     first_reg;
    vtx_t                     cx_reg;
    vtx_t                     rv_reg;
    logic signed [DIST_W-1:0] prev_d_reg;
    logic signed [DIST_W-1:0] cur_d_reg;
    logic signed [DIST_W-1:0] first_d_reg;
    logic [DEN_W:0]           rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [Q_W-1:0]           q_reg;
    logic signed [PW-1:0]     prod_reg;

    vtx_t                     src_vtx;
    logic signed [DIST_W-1:0] d_cur;
    logic signed [DIST_W-1:0] dc_sel;
    logic signed [DEN_W-1:0]  dp_ext;
    logic signed [DEN_W-1:0]  diff;
    logic                     at_end;
    logic                     prev_in;
    logic                     div_ge;
    logic [DEN_W:0]           rem_sub;
    logic signed [32:0]       delta;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     rnd;
    logic signed [PW-1:0]     shifted;

    always_comb begin
        src_vtx   = vmem_reg[bank_reg][i_reg];
        d_cur     = htclip_dist(src_vtx, plane_reg);
        at_end    = (i_reg == n_reg);
        dc_sel    = at_end ? first_d_reg : d_cur;
        dp_ext    = DEN_W'(prev_d_reg);
        diff      = dp_ext - DEN_W'(dc_sel);
        prev_in   = (prev_d_reg > 0);
        div_ge    = (rem_reg >= {1'b0, den_reg});
        rem_sub   = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        delta     = 33'($signed(cx_reg[k_reg])) - 33'($signed(prev_reg[k_reg]));
        prod_next = PW'(delta) * PW'($signed({1'b0, q_reg}));
        rnd       = prod_reg + HALF;
        shifted   = rnd >>> FRACTION_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            n_reg     <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            plane_reg <= PL_W_POS;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int v = 0; v < 3; v++) begin
                            for (int c = 0; c < 4; c++) begin
                                vmem_reg[0][v][c] <= s_tdata[(v*4+c)*COORD_W +: COORD_W];
                            end
                        end
                        bank_reg  <= 1'b0;
                        n_reg     <= IDX_W'(3);
                        m_reg     <= '0;
                        i_reg     <= '0;
                        plane_reg <= PL_W_POS;
                        state_reg <= ST_VISIT;
                    end
                end
                ST_VISIT: begin
                    cur_reg   <= src_vtx;
                    cur_d_reg <= d_cur;
                    if (!at_end && i_reg == '0) begin
                        first_reg   <= src_vtx;
                        first_d_reg <= d_cur;
                    end
                    // set up a crossing on edge prev->cur, or on the closing edge
                    rem_reg     <= {1'b0, htclip_mag(dp_ext)};
                    den_reg     <= htclip_mag(diff);
                    q_reg       <= '0;
                    cnt_reg     <= CNT_W'(FRACTION_BITS);
                    closing_reg <= at_end;
                    cx_reg      <= at_end ? first_reg : src_vtx;
                    if (at_end) begin
                        state_reg <= (prev_in != (first_d_reg > 0)) ? ST_DIV : ST_NEXT;
                    end else if (i_reg != '0 && prev_in != (d_cur > 0)) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_KEEP;
                    end
                end
                ST_KEEP: begin
                    if (cur_d_reg > 0 && m_reg < IDX_W'(MAX_VERTS)) begin
                        vmem_reg[~bank_reg][m_reg] <= cur_reg;
                        m_reg <= m_reg + 1'b1;
                    end
                    prev_reg   <= cur_reg;
                    prev_d_reg <= cur_d_reg;
                    i_reg      <= i_reg + 1'b1;
                    state_reg  <= ST_VISIT;
                end
                ST_DIV: begin
                    q_reg   <= {q_reg[Q_W-2:0], div_ge};
                    rem_reg <= {rem_sub[DEN_W-1:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        k_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    rv_reg[k_reg] <= prev_reg[k_reg] + shifted[COORD_W-1:0];
                    k_reg         <= k_reg + 1'b1;
                    state_reg     <= (k_reg == 2'd3) ? ST_PUSHX : ST_MUL;
                end
                ST_PUSHX: begin
                    if (m_reg < IDX_W'(MAX_VERTS)) begin
                        vmem_reg[~bank_reg][m_reg] <= rv_reg;
                        m_reg <= m_reg + 1'b1;
                    end
                    state_reg <= closing_reg ? ST_NEXT : ST_KEEP;
                end
                ST_NEXT: begin
                    bank_reg  <= ~bank_reg;
                    n_reg     <= m_reg;
                    m_reg     <= '0;
                    i_reg     <= '0;
                    plane_reg <= plane_reg + 1'b1;
                    if (m_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else if (plane_reg == PL_Y_BOT) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_VISIT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == n_reg - 1'b1) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = (i_reg == n_reg - 1'b1);
    assign m_tdata  = {4'b0000, i_reg, src_vtx[3], src_vtx[2], src_vtx[1], src_vtx[0]};

    a_valid_has_items: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (n_reg != '0 && n_reg <= IDX_W'(MAX_VERTS) && i_reg < n_reg))
        else $error("output beat outside polygon");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_reg <= IDX_W'(MAX_VERTS))
        else $error("working list overflow");

    a_not_both_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while emitting");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("did not return to idle after last beat");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import htclip_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic [3:0]  num;
        logic        last;
    } clip_vtx_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    clip_vtx_t clipped_q[$];
    int        mismatches;
    int        idle_cycles;

    homogeneous_triangle_clipper_top #(.FRACTION_BITS(FRAC)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic signed [63:0] plane_distance(logic signed [63:0] c[4], int plane);
        case (plane)
            PL_W_POS:  return c[3];
            PL_Z_NEAR: return c[2] + c[3];
            PL_Z_FAR:  return c[3] - c[2];
            PL_X_LEFT: return c[0] + c[3];
            PL_X_RGHT: return c[3] - c[0];
            PL_Y_TOP:  return c[3] - c[1];
            default:   return c[1] + c[3];
        endcase
    endfunction

    // Round a wide signed product to nearest at 2^FRAC, ties toward plus infinity.
    function automatic logic signed [63:0] round_frac(logic signed [127:0] p);
        logic signed [127:0] r;
        r = (p + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        return r[63:0];
    endfunction

    // Clip one triangle through all planes; queue the surviving vertices.
    task automatic predict_clip(input logic [S_TDATA_W-1:0] tri_bits);
        logic signed [63:0] poly [10][4];
        logic signed [63:0] nxt [10][4];
        logic signed [63:0] dvals [10];
        logic signed [63:0] pv [4];
        logic signed [63:0] diff_d;
        logic [63:0]        num_u;
        logic [63:0]        den_u;
        logic [63:0]        t;
        logic signed [127:0] prod;
        int n;
        int m;
        int a;
        int b;
        clip_vtx_t v;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 4; k++)
                poly[i][k] = 64'($signed(tri_bits[(i*4+k)*32 +: 32]));
        n = 3;
        for (int p = 0; p < NUM_PLANES && n > 0; p++) begin
            for (int i = 0; i < n; i++) begin
                for (int k = 0; k < 4; k++) pv[k] = poly[i][k];
                dvals[i] = plane_distance(pv, p);
            end
            m = 0;
            // crossing on edge (s-1,s) before vertex s; s == n is the closing edge
            for (int s = 0; s <= n; s++) begin
                if (s > 0) begin
                    a = s - 1;
                    b = (s == n) ? 0 : s;
                    if ((dvals[a] > 0) != (dvals[b] > 0)) begin
                        num_u  = (dvals[a] < 0) ? -dvals[a] : dvals[a];
                        diff_d = dvals[a] - dvals[b];
                        den_u  = (diff_d < 0) ? -diff_d : diff_d;
                        t = (num_u << FRAC) / den_u;
                        if (m < MAX_VERTS) begin
                            for (int k = 0; k < 4; k++) begin
                                prod = 128'(poly[b][k] - poly[a][k]) * $signed({64'd0, t});
                                nxt[m][k] = poly[a][k] + round_frac(prod);
                            end
                            m++;
                        end
                    end
                end
                if (s < n && dvals[s] > 0 && m < MAX_VERTS) begin
                    for (int k = 0; k < 4; k++) nxt[m][k] = poly[s][k];
                    m++;
                end
            end
            for (int i = 0; i < m; i++)
                for (int k = 0; k < 4; k++) poly[i][k] = nxt[i][k];
            n = m;
        end
        for (int i = 0; i < n; i++) begin
            v.x = poly[i][0][31:0];
            v.y = poly[i][1][31:0];
            v.z = poly[i][2][31:0];
            v.w = poly[i][3][31:0];
            v.num = 4'(i);
            v.last = (i == n - 1);
            clipped_q = {clipped_q, v};
        end
    endtask

    function automatic logic [S_TDATA_W-1:0] make_tri(
        logic [31:0] c[12]);
        logic [S_TDATA_W-1:0] r;
        for (int i = 0; i < 12; i++) r[i*32 +: 32] = c[i];
        return r;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            2:       return 32'($signed($urandom_range(0, 8)) - 4) << FRAC;
            3:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    // Mostly near the frustum: w in about [-0.25, 3.75], x,y,z within +-8; one in five is noisy.
    function automatic logic [S_TDATA_W-1:0] rnd_tri();
        logic [31:0] c[12];
        logic signed [31:0] w;
        bit noisy;
        noisy = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 3; i++) begin
            if (noisy) begin
                for (int k = 0; k < 4; k++) c[i*4+k] = rnd_coord();
            end else begin
                w = $signed($urandom_range(0, 4 << FRAC)) - (1 << (FRAC - 2));
                for (int k = 0; k < 3; k++)
                    c[i*4+k] = $signed($urandom_range(0, 16 << FRAC)) - (8 << FRAC);
                c[i*4+3] = w;
            end
        end
        return make_tri(c);
    endfunction

    // Leaves tvalid high after the beat; the caller drops it when done.
    task automatic send_triangle(input logic [S_TDATA_W-1:0] bits);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= bits;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_clip(bits);
    endtask

    // Result side: random stalls, check every beat.
    initial begin
        clip_vtx_t exp_v;
        clip_vtx_t got;
        int wait_n;
        m_tready = 1'b0;
        mismatches = 0;
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (wait_n != 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            got.x = m_tdata[31:0];
            got.y = m_tdata[63:32];
            got.z = m_tdata[95:64];
            got.w = m_tdata[127:96];
            got.num = m_tdata[131:128];
            got.last = m_tlast;
            if (clipped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex beat %p", got);
            end else begin
                exp_v = clipped_q.pop_front();
                if (got !== exp_v) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: expected %p got %p", exp_v, got);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    logic [31:0] dir_tab [20][12];

    initial begin
        logic [31:0] one;
        int n_dir;
        int drain;
        one = 32'h00010000;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        // fully inside, fully outside, one plane cut, four side planes cut, on-plane, extremes
        dir_tab[0]  = '{0, 0, 0, one, one>>1, 0, 0, one, 0, one>>1, 0, one};
        dir_tab[1]  = '{0, 0, 0, -one, one, 0, 0, -one, 0, one, 0, -one};
        dir_tab[2]  = '{0, 0, 0, one, 3*one, 0, 0, one, 0, one>>1, 0, one};
        dir_tab[3]  = '{-5*one, -5*one, 0, one, 5*one, -5*one, 0, one, 0, 5*one, 0, one};
        dir_tab[4]  = '{one, 0, 0, one, one, one>>2, 0, one, one, 0, one>>2, one};
        dir_tab[5]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[6]  = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF};
        dir_tab[7]  = '{32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF,
                        0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF};
        dir_tab[8]  = '{0, 0, -3*one, one, one>>1, 0, 3*one, one, 0, one>>1, 0, one};
        dir_tab[9]  = '{0, 0, 0, one, 0, 0, 0, -one, one>>1, 0, 0, one};
        dir_tab[10] = '{-one, -one, -one, one, one, one, one, one, 0, 0, 0, one};
        dir_tab[11] = '{-3*one, 0, 0, one, 3*one, 0, 0, one, 0, 3*one, 0, one};
        dir_tab[12] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                        1, 1, 1, 1, 32'h55555555, 32'hAAAAAAAA, 32'h12345678, 32'h7FFF0000};
        n_dir = 13;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < n_dir; i++) send_triangle(make_tri(dir_tab[i]));
        for (int i = 0; i < 97; i++) begin
            send_triangle(rnd_tri());
            if (i == 40) begin
                // hold off until every queued vertex has come out
                s_tvalid <= 1'b0;
                wait (clipped_q.size() == 0);
            end
        end
        s_tvalid <= 1'b0;
        drain = 0;
        while (clipped_q.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && clipped_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
